/* rtl/g2b_pkg.sv */
// g2b_pkg: shared sizes, register map, reset values and item types for the
// gray to bitonal error diffusion block. No dependencies.
package g2b_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int WORD_BITS = 32;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);

    localparam int PIX_W  = 8;
    localparam int ERR_W  = 9;
    localparam int CFG_WIDTH_W = 13;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_BLACK  = 2'd1,
        REG_THRESH = 2'd2,
        REG_WIDTH  = 2'd3
    } g2b_reg_t;

    // mode_select codes
    localparam logic MODE_DIFFUSE = 1'b0;
    localparam logic MODE_THRESH  = 1'b1;

    localparam logic                   RST_MODE   = MODE_DIFFUSE;
    localparam logic                   RST_BLACK  = 1'b1;
    localparam logic [PIX_W-1:0]       RST_THRESH = 8'd128;
    localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH  = 13'd4096;

    localparam logic [PIX_W-1:0] PIX_INVERT = 8'hff;

    // Configuration as seen by the datapath (width already clamped).
    typedef struct packed {
        logic             diffuse;
        logic             black_is_zero;
        logic [PIX_W-1:0] threshold;
        logic [CNT_W-1:0] width;
    } g2b_cfg_t;

    // One classified pixel on its way from front to back.
    typedef struct packed {
        logic             diffuse;
        logic             new_image;
        logic             thr_black;
        logic [PIX_W-1:0] pix;
    } g2b_item_t;

endpackage

/* rtl/g2b_ram.sv */
// g2b_ram: generic RAM, one write port and two registered read ports.
// Stands alone; no package needed.
module g2b_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/g2b_front.sv */
// g2b_front: input side; accepts gray pixels and classifies them for the back end.
// Depends on g2b_pkg.
module g2b_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [g2b_pkg::PIX_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  g2b_pkg::g2b_cfg_t         cfg,
    input  logic                      q_full,
    output logic                      push,
    output g2b_pkg::g2b_item_t        push_item
);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        push_item.diffuse   = cfg.diffuse;
        push_item.new_image = s_tuser;
        // invert so that a low value always means dark
        push_item.pix       = cfg.black_is_zero ? s_tdata : (s_tdata ^ g2b_pkg::PIX_INVERT);
        if (cfg.black_is_zero)
        begin
            push_item.thr_black = s_tdata < cfg.threshold;
        end
        else
        begin
            push_item.thr_black = s_tdata >= cfg.threshold;
        end
    end

endmodule

/* rtl/g2b_queue.sv */
// g2b_queue: short FIFO of classified pixels between front and back.
// Depends on g2b_pkg.
module g2b_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  g2b_pkg::g2b_item_t push_item,
    output logic               full,
    output logic               q_valid,
    output g2b_pkg::g2b_item_t q_item,
    input  logic               pop
);

    g2b_pkg::g2b_item_t            entry_reg [g2b_pkg::Q_DEPTH];
    logic [g2b_pkg::QP_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [g2b_pkg::QP_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [g2b_pkg::QC_W-1:0]      count_reg, count_next;

    function automatic logic [g2b_pkg::QP_W-1:0] ptr_inc(input logic [g2b_pkg::QP_W-1:0] p);
        if (p == g2b_pkg::QP_W'(g2b_pkg::Q_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full    = (count_reg == g2b_pkg::QC_W'(g2b_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/g2b_back.sv */
// g2b_back: per-pixel diffusion or threshold step, row error buffer, bit packing
// and output register. Depends on g2b_pkg and g2b_ram.
module g2b_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  g2b_pkg::g2b_cfg_t             cfg,
    input  logic                          q_valid,
    input  g2b_pkg::g2b_item_t            q_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [g2b_pkg::WORD_BITS-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int SUM_W = g2b_pkg::ERR_W + 5;
    localparam int VAL_W = g2b_pkg::ERR_W + 2;
    localparam int AW    = g2b_pkg::ADDR_W;
    localparam int CW    = g2b_pkg::CNT_W;
    localparam int BW    = g2b_pkg::BIT_W;
    localparam int WB    = g2b_pkg::WORD_BITS;
    localparam int EW    = g2b_pkg::ERR_W;

    localparam logic signed [VAL_W-1:0] WHITE_LEVEL = VAL_W'(128);
    localparam logic signed [VAL_W-1:0] WHITE_SUB   = VAL_W'(255);

    logic [AW-1:0]        col_reg, col_next;
    logic [CW-1:0]        hw_reg, hw_next;
    logic signed [EW-1:0] left_reg, left_next;
    logic signed [EW-1:0] al_reg, al_next;
    logic [WB-1:0]        pack_reg, pack_next;
    logic [BW-1:0]        bitpos_reg, bitpos_next;
    logic                 a_vld_reg, a_vld_next;
    logic                 ar_vld_reg, ar_vld_next;
    logic                 a_byp_reg, a_byp_next;
    logic                 ar_byp_reg, ar_byp_next;
    logic [EW-1:0]        byp_reg, byp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WB-1:0]        out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 fire;
    logic                 ni;
    logic [AW-1:0]        c;
    logic [CW-1:0]        hw;
    logic [CW-1:0]        cnt;
    logic                 row_done;
    logic                 at_fill;
    logic signed [EW-1:0] left_s, al_s, above_s, ar_s;
    logic [EW-1:0]        rd_a, rd_b;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] val;
    logic signed [EW-1:0] err;
    logic                 black;
    logic [WB-1:0]        pack_set;
    logic [BW-1:0]        bp;
    logic                 emit;
    logic                 ram_we;
    logic [EW-1:0]        ram_wdata;
    logic [AW-1:0]        nc;
    logic [CW-1:0]        nc_a, nc_ar;

    assign fire = q_valid && (!out_valid_reg || m_tready);
    assign pop  = fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // new image restarts everything before the pixel is used
    assign ni = q_item.new_image;
    assign c  = ni ? '0 : col_reg;
    assign hw = ni ? '0 : hw_reg;
    assign bp = ni ? '0 : bitpos_reg;

    assign cnt      = CW'(c) + 1'b1;
    assign row_done = cnt >= cfg.width;
    assign at_fill  = (CW'(c) == hw);

    always_comb
    begin
        left_s  = ni ? '0 : left_reg;
        al_s    = ni ? '0 : al_reg;
        above_s = '0;
        ar_s    = '0;
        if (!ni)
        begin
            if (a_byp_reg)
            begin
                above_s = $signed(byp_reg);
            end
            else if (a_vld_reg)
            begin
                above_s = $signed(rd_a);
            end
            if (cnt < cfg.width)
            begin
                if (ar_byp_reg)
                begin
                    ar_s = $signed(byp_reg);
                end
                else if (ar_vld_reg)
                begin
                    ar_s = $signed(rd_b);
                end
            end
        end
    end

    // weights 7, 1, 5, 3 as shift and add
    always_comb
    begin
        sum = (SUM_W'(left_s) <<< 3) - SUM_W'(left_s)
            + SUM_W'(al_s)
            + (SUM_W'(above_s) <<< 2) + SUM_W'(above_s)
            + (SUM_W'(ar_s) <<< 1) + SUM_W'(ar_s);
        val = VAL_W'(sum >>> 4) + $signed({3'b000, q_item.pix});
        if (val >= WHITE_LEVEL)
        begin
            err = EW'(val - WHITE_SUB);
        end
        else
        begin
            err = EW'(val);
        end
    end

    assign black    = q_item.diffuse ? (val < WHITE_LEVEL) : q_item.thr_black;
    assign pack_set = (ni ? '0 : pack_reg)
                    | (black ? (WB'(1) << (BW'(WB - 1) - bp)) : '0);
    assign emit     = row_done || (bp == BW'(WB - 1));

    // an entry at the fill mark is still logically zero, so threshold steps
    // may write zero there and keep the written columns a contiguous prefix
    assign ram_we    = fire && (q_item.diffuse || at_fill);
    assign ram_wdata = q_item.diffuse ? err : '0;

    assign nc    = row_done ? '0 : cnt[AW-1:0];
    assign nc_a  = CW'(nc);
    assign nc_ar = CW'(nc) + 1'b1;

    always_comb
    begin
        col_next       = col_reg;
        hw_next        = hw_reg;
        left_next      = left_reg;
        al_next        = al_reg;
        pack_next      = pack_reg;
        bitpos_next    = bitpos_reg;
        a_vld_next     = a_vld_reg;
        ar_vld_next    = ar_vld_reg;
        a_byp_next     = a_byp_reg;
        ar_byp_next    = ar_byp_reg;
        byp_next       = byp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            col_next = nc;
            hw_next  = at_fill ? hw + 1'b1 : hw;
            if (row_done)
            begin
                left_next = '0;
                al_next   = '0;
            end
            else if (q_item.diffuse)
            begin
                left_next = err;
                al_next   = above_s;
            end
            else
            begin
                left_next = left_s;
                al_next   = al_s;
            end

            if (emit)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pack_set;
                out_last_next  = row_done;
                pack_next      = '0;
                bitpos_next    = '0;
            end
            else
            begin
                pack_next   = pack_set;
                bitpos_next = bp + 1'b1;
            end

            // prefetch the two entries the next pixel reads
            a_vld_next  = nc_a < hw_next;
            ar_vld_next = nc_ar < hw_next;
            a_byp_next  = ram_we && (nc_a == CW'(c));
            ar_byp_next = ram_we && (nc_ar == CW'(c));
            byp_next    = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            hw_reg        <= '0;
            left_reg      <= '0;
            al_reg        <= '0;
            pack_reg      <= '0;
            bitpos_reg    <= '0;
            a_vld_reg     <= 1'b0;
            ar_vld_reg    <= 1'b0;
            a_byp_reg     <= 1'b0;
            ar_byp_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            hw_reg        <= hw_next;
            left_reg      <= left_next;
            al_reg        <= al_next;
            pack_reg      <= pack_next;
            bitpos_reg    <= bitpos_next;
            a_vld_reg     <= a_vld_next;
            ar_vld_reg    <= ar_vld_next;
            a_byp_reg     <= a_byp_next;
            ar_byp_reg    <= ar_byp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg      <= byp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    g2b_ram #(
        .WIDTH (EW),
        .DEPTH (g2b_pkg::MAX_WIDTH)
    ) u_row_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (c),
        .wdata   (ram_wdata),
        .re      (fire),
        .raddr_a (nc_a[AW-1:0]),
        .raddr_b (nc_ar[AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CW'(g2b_pkg::MAX_WIDTH))
        else $error("fill mark beyond buffer depth");

    a_col_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(col_reg) <= hw_reg)
        else $error("column ahead of fill mark");

    a_row_start_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg == '0) |-> (bitpos_reg == '0))
        else $error("row start with partial word");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> out_valid_reg)
        else $error("emitted word not presented");

endmodule

/* rtl/gray_to_bitonal_error_diffusion.sv */
// gray_to_bitonal_error_diffusion: top level; APB registers, front, queue, back.
// Depends on g2b_pkg, g2b_front, g2b_queue, g2b_back, g2b_ram.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+----------------------------------
//  s_*      | in  | s_tvalid / s_tready       | s_tdata[7:0] gray_pixel,
//           |     |                           | s_tuser new_image
//  m_*      | out | m_tvalid / m_tready       | m_tdata[31:0] packed_bits,
//           |     |                           | m_tlast row_end
//  apb      | in  | psel, penable, pready = 1 | 0x0 mode_select, 0x4 black_is_zero,
//           |     |                           | 0x8 threshold_level, 0xc row_width
//
// One pixel per clock sustained while the output is not stalled; an input
// transfer goes through the queue, then the back-end step that writes the output
// register. The per-pixel step, with its left-error feedback and the row buffer's
// two prefetch reads, sets that rate.
// Reset clears control state at once; the row buffer is covered by a fill mark,
// so no clearing pass is needed after reset or on a new image.
// A stalled output holds the back end; the two-entry queue then fills and drops
// s_tready, so each side stalls on its own.
module gray_to_bitonal_error_diffusion (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream: tdata = gray_pixel[7:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [g2b_pkg::PIX_W-1:0]      s_tdata,
    // tuser = new_image
    input  logic                           s_tuser,
    // master stream: tdata = packed_bits[31:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [g2b_pkg::WORD_BITS-1:0]  m_tdata,
    // tlast = row_end
    output logic                           m_tlast,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [g2b_pkg::APB_AW-1:0]     paddr,
    input  logic [g2b_pkg::APB_DW-1:0]     pwdata,
    output logic [g2b_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    logic                                mode_reg, mode_next;
    logic                                black_reg, black_next;
    logic [g2b_pkg::PIX_W-1:0]           thresh_reg, thresh_next;
    logic [g2b_pkg::CFG_WIDTH_W-1:0]     width_reg, width_next;

    logic                                wr_fire;
    g2b_pkg::g2b_reg_t                   reg_idx;
    g2b_pkg::g2b_cfg_t                   cfg;

    logic                                q_full;
    logic                                push;
    g2b_pkg::g2b_item_t                  push_item;
    logic                                q_valid;
    g2b_pkg::g2b_item_t                  q_item;
    logic                                pop;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign reg_idx = g2b_pkg::g2b_reg_t'(paddr[3:2]);

    // register writes land on the access cycle
    always_comb
    begin
        mode_next   = mode_reg;
        black_next  = black_reg;
        thresh_next = thresh_reg;
        width_next  = width_reg;
        if (wr_fire)
        begin
            case (reg_idx)
                g2b_pkg::REG_MODE:   mode_next   = pwdata[0];
                g2b_pkg::REG_BLACK:  black_next  = pwdata[0];
                g2b_pkg::REG_THRESH: thresh_next = pwdata[g2b_pkg::PIX_W-1:0];
                g2b_pkg::REG_WIDTH:  width_next  = pwdata[g2b_pkg::CFG_WIDTH_W-1:0];
                default:             mode_next   = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            g2b_pkg::REG_MODE:   prdata = g2b_pkg::APB_DW'(mode_reg);
            g2b_pkg::REG_BLACK:  prdata = g2b_pkg::APB_DW'(black_reg);
            g2b_pkg::REG_THRESH: prdata = g2b_pkg::APB_DW'(thresh_reg);
            g2b_pkg::REG_WIDTH:  prdata = g2b_pkg::APB_DW'(width_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= g2b_pkg::RST_MODE;
            black_reg  <= g2b_pkg::RST_BLACK;
            thresh_reg <= g2b_pkg::RST_THRESH;
            width_reg  <= g2b_pkg::RST_WIDTH;
        end
        else
        begin
            mode_reg   <= mode_next;
            black_reg  <= black_next;
            thresh_reg <= thresh_next;
            width_reg  <= width_next;
        end
    end

    // clamp the row width: zero acts as one, anything past the buffer as full depth
    always_comb
    begin
        cfg.diffuse       = (mode_reg == g2b_pkg::MODE_DIFFUSE);
        cfg.black_is_zero = black_reg;
        cfg.threshold     = thresh_reg;
        if (width_reg == '0)
        begin
            cfg.width = g2b_pkg::CNT_W'(1);
        end
        else if (32'(width_reg) > g2b_pkg::MAX_WIDTH)
        begin
            cfg.width = g2b_pkg::CNT_W'(g2b_pkg::MAX_WIDTH);
        end
        else
        begin
            cfg.width = g2b_pkg::CNT_W'(width_reg);
        end
    end

    g2b_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    g2b_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    g2b_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
